// ----- rtl/core/utf8_dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// Widths and lead byte patterns shared by the utf-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

    // field and state widths
    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int PARTIAL_W = 18;
    localparam int REM_W     = 2;
    localparam int CONT_W    = 6;
    localparam int TDATA_W   = ((CP_W + 7) / 8) * 8;

    // lead byte masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_VAL  = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

    // payload masks
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    // continuation bytes still expected after each lead
    localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

endpackage

// ----- rtl/core/utf8_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Lenient utf-8 decoder: one byte in per transaction, code points out.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and sustains one byte per clock with no
// gaps while m_axis_tready stays high; each result is decoded from the input
// register, which loads on acceptance, through the single decode stage into
// the result register. A stalled result holds the input register and, once
// it is full, drops s_axis_tready until m_axis_tready returns. A lead byte
// starts a 1 to 4 byte sequence; following bytes are used as continuation
// bytes without checking their top bits. Bad lead bytes are dropped silently.
// The byte marked with tlast always yields one result with tlast set; its
// tuser bit (point valid) is clear when no sequence finished on it, and then
// the code point is zero. No overlong, surrogate or range checks.
module utf8_byte_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // point_valid
    output logic        m_axis_tlast    // string_end
);

    localparam int BW = utf8_dec_pkg::BYTE_W;
    localparam int CW = utf8_dec_pkg::CP_W;
    localparam int PW = utf8_dec_pkg::PARTIAL_W;
    localparam int RW = utf8_dec_pkg::REM_W;
    localparam int XW = utf8_dec_pkg::CONT_W;

    // input stage
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;
    logic          in_last_reg;

    // decoder state
    logic [RW-1:0] rem_reg,     rem_next;
    logic [PW-1:0] partial_reg, partial_next;

    // result stage
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_cp_reg;
    logic          out_pv_reg;
    logic          out_end_reg;

    logic          out_ready;
    logic          fire;
    logic          done;
    logic          emit;
    logic [CW-1:0] cp;
    logic [PW+XW-1:0] acc;

    // handshake
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign fire          = in_valid_reg && out_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // decode one byte against the current sequence state
    always_comb
    begin
        acc          = {partial_reg, in_byte_reg[XW-1:0]};
        rem_next     = rem_reg;
        partial_next = partial_reg;
        done         = 1'b0;
        cp           = '0;

        if (rem_reg != utf8_dec_pkg::REM_NONE)
        begin
            rem_next = rem_reg - utf8_dec_pkg::REM_ONE;
            if (rem_reg == utf8_dec_pkg::REM_ONE)
            begin
                cp           = acc[CW-1:0];
                done         = 1'b1;
                partial_next = '0;
            end
            else
            begin
                partial_next = acc[PW-1:0];
            end
        end
        else if ((in_byte_reg & utf8_dec_pkg::ASCII_MASK) == utf8_dec_pkg::ASCII_VAL)
        begin
            cp   = CW'(in_byte_reg);
            done = 1'b1;
        end
        else if ((in_byte_reg & utf8_dec_pkg::LEAD2_MASK) == utf8_dec_pkg::LEAD2_VAL)
        begin
            partial_next = PW'(in_byte_reg & utf8_dec_pkg::LEAD2_BITS);
            rem_next     = utf8_dec_pkg::REM_ONE;
        end
        else if ((in_byte_reg & utf8_dec_pkg::LEAD3_MASK) == utf8_dec_pkg::LEAD3_VAL)
        begin
            partial_next = PW'(in_byte_reg & utf8_dec_pkg::LEAD3_BITS);
            rem_next     = utf8_dec_pkg::REM_TWO;
        end
        else if ((in_byte_reg & utf8_dec_pkg::LEAD4_MASK) == utf8_dec_pkg::LEAD4_VAL)
        begin
            partial_next = PW'(in_byte_reg & utf8_dec_pkg::LEAD4_BITS);
            rem_next     = utf8_dec_pkg::REM_THREE;
        end

        // end of string drops any unfinished sequence
        if (in_last_reg)
        begin
            rem_next     = utf8_dec_pkg::REM_NONE;
            partial_next = '0;
        end

        emit = done || in_last_reg;
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= utf8_dec_pkg::REM_NONE;
            partial_reg <= '0;
        end
        else if (fire)
        begin
            rem_reg     <= rem_next;
            partial_reg <= partial_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_cp_reg  <= cp;
            out_pv_reg  <= done;
            out_end_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(utf8_dec_pkg::TDATA_W - CW)'(0), out_cp_reg};
    assign m_axis_tuser  = out_pv_reg;
    assign m_axis_tlast  = out_end_reg;

    // a result without a code point only comes from the end of a string
    a_invalid_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("result without code point outside string end");

    // the end of a string leaves no sequence open
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> (rem_reg == utf8_dec_pkg::REM_NONE && partial_reg == '0))
        else $error("sequence state not cleared after string end");

    // gathered payload never exceeds what the pending byte count allows
    a_partial_one: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == utf8_dec_pkg::REM_ONE) |-> (partial_reg[PW-1:15] == '0))
        else $error("partial bits too wide with one byte left");

    a_partial_more: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == utf8_dec_pkg::REM_TWO) |-> (partial_reg[PW-1:9] == '0))
        else $error("partial bits too wide with two bytes left");

endmodule

// ----- tb/utf8_decode_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both stream channels of the utf-8 byte decoder, predicts the code
// point that each accepted byte yields and compares the results in order.
// ----------------------------------------------------------------------------
module utf8_decode_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // last_byte

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        m_axis_tuser,   // point_valid
    input  logic        m_axis_tlast,   // string_end

    output int          mismatches,
    output int          pending
);

    localparam int BYTE_W    = utf8_dec_pkg::BYTE_W;
    localparam int CP_W      = utf8_dec_pkg::CP_W;
    localparam int PARTIAL_W = utf8_dec_pkg::PARTIAL_W;
    localparam int REM_W     = utf8_dec_pkg::REM_W;
    localparam int CONT_W    = utf8_dec_pkg::CONT_W;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            point_valid;
        logic            string_end;
    } point_t;

    // predicted decoder state
    logic [REM_W-1:0]     cont_left;
    logic [PARTIAL_W-1:0] payload;

    // code points still owed by the block, oldest first
    point_t expected_points[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
        cont_left  = utf8_dec_pkg::REM_NONE;
        payload    = '0;
    end

    // work out the result, if any, that one accepted byte causes
    task automatic decode_next_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [PARTIAL_W+CONT_W-1:0] acc;
        logic                        done;
        logic [CP_W-1:0]             cp;
        point_t                      point;
        done = 1'b0;
        cp   = '0;
        if (cont_left != utf8_dec_pkg::REM_NONE)
        begin
            // continuation: top bits are not checked
            acc       = {payload, 6'b0} |
                        {{PARTIAL_W{1'b0}}, 6'(b & utf8_dec_pkg::CONT_BITS)};
            cont_left = cont_left - utf8_dec_pkg::REM_ONE;
            if (cont_left == utf8_dec_pkg::REM_NONE)
            begin
                cp      = acc[CP_W-1:0];
                done    = 1'b1;
                payload = '0;
            end
            else
            begin
                payload = acc[PARTIAL_W-1:0];
            end
        end
        else if ((b & utf8_dec_pkg::ASCII_MASK) == utf8_dec_pkg::ASCII_VAL)
        begin
            cp   = {{(CP_W-BYTE_W){1'b0}}, b};
            done = 1'b1;
        end
        else if ((b & utf8_dec_pkg::LEAD2_MASK) == utf8_dec_pkg::LEAD2_VAL)
        begin
            payload   = {{(PARTIAL_W-BYTE_W){1'b0}}, b & utf8_dec_pkg::LEAD2_BITS};
            cont_left = utf8_dec_pkg::REM_ONE;
        end
        else if ((b & utf8_dec_pkg::LEAD3_MASK) == utf8_dec_pkg::LEAD3_VAL)
        begin
            payload   = {{(PARTIAL_W-BYTE_W){1'b0}}, b & utf8_dec_pkg::LEAD3_BITS};
            cont_left = utf8_dec_pkg::REM_TWO;
        end
        else if ((b & utf8_dec_pkg::LEAD4_MASK) == utf8_dec_pkg::LEAD4_VAL)
        begin
            payload   = {{(PARTIAL_W-BYTE_W){1'b0}}, b & utf8_dec_pkg::LEAD4_BITS};
            cont_left = utf8_dec_pkg::REM_THREE;
        end
        // other lead bytes are dropped silently

        // end of string clears any unfinished sequence
        if (last)
        begin
            cont_left = utf8_dec_pkg::REM_NONE;
            payload   = '0;
        end

        if (done || last)
        begin
            point.code_point  = cp;
            point.point_valid = done;
            point.string_end  = last;
            expected_points   = {expected_points, point};
        end
    endtask

    // compare one result transaction with the oldest prediction
    task automatic check_result();
        point_t want;
        if (expected_points.size() == 0)
        begin
            $error("unexpected result: code_point 0x%06h point_valid %0d string_end %0d",
                   m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
            mismatches <= mismatches + 1;
        end
        else
        begin
            want = expected_points.pop_front();
            if (m_axis_tdata[CP_W-1:0] !== want.code_point ||
                m_axis_tdata[23:CP_W] !== '0 ||
                m_axis_tuser !== want.point_valid ||
                m_axis_tlast !== want.string_end)
            begin
                if (m_axis_tdata[CP_W-1:0] !== want.code_point)
                    $error("code_point mismatch: expected 0x%06h, actual 0x%06h",
                           want.code_point, m_axis_tdata[CP_W-1:0]);
                if (m_axis_tdata[23:CP_W] !== '0)
                    $error("tdata pad mismatch: expected 0x0, actual 0x%0h",
                           m_axis_tdata[23:CP_W]);
                if (m_axis_tuser !== want.point_valid)
                    $error("point_valid mismatch: expected %0d, actual %0d",
                           want.point_valid, m_axis_tuser);
                if (m_axis_tlast !== want.string_end)
                    $error("string_end mismatch: expected %0d, actual %0d",
                           want.string_end, m_axis_tlast);
                mismatches <= mismatches + 1;
            end
        end
    endtask

    // results are checked before the byte of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                check_result();
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                decode_next_byte(s_axis_tdata, s_axis_tlast);
            pending <= expected_points.size();
        end
    end

endmodule

// ----- tb/tb_utf8_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_decoder
// Feeds byte strings to the utf-8 byte decoder: a directed set of corner
// cases, then random strings of well-formed, truncated and junk sequences,
// under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_utf8_byte_decoder;

    localparam int PHASE_BYTES = 287;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        s_axis_tlast;    // last_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;    // [20:0] code_point, [23:21] zero
    logic        m_axis_tuser;    // point_valid
    logic        m_axis_tlast;    // string_end

    int          mismatches;
    int          pending;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          bytes_sent     = 0;

    // bytes of the string being built, sent with tlast on the final one
    logic [7:0]  str_bytes[$];

    always #2 clk = ~clk;

    utf8_byte_decoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_decode_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // one byte transaction, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    // append one byte to the string being built
    task automatic add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    // continuation byte, now and then with arbitrary top bits
    function automatic logic [7:0] rand_cont();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // lead byte of an n-byte sequence followed by k continuation bytes
    task automatic add_sequence(input int n, input int k);
        int j;
        case (n)
            2:       add_byte(utf8_dec_pkg::LEAD2_VAL | 8'($urandom_range(0, 31)));
            3:       add_byte(utf8_dec_pkg::LEAD3_VAL | 8'($urandom_range(0, 15)));
            4:       add_byte(utf8_dec_pkg::LEAD4_VAL | 8'($urandom_range(0, 7)));
            default: add_byte(8'($urandom_range(0, 127)));
        endcase
        for (j = 0; j < k; j++)
            add_byte(rand_cont());
    endtask

    // random string: mostly valid characters, some junk leads, sometimes cut short
    task automatic send_random_string();
        int n_chars;
        int c;
        int r;
        int n;
        n_chars = $urandom_range(1, 6);
        for (c = 0; c < n_chars; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                add_sequence(1, 0);
            else if (r < 90)
            begin
                n = (r < 50) ? 2 : (r < 70) ? 3 : 4;
                add_sequence(n, n - 1);
            end
            else if (r < 95)
                add_byte(8'h80 | 8'($urandom_range(0, 63)));
            else
                add_byte(8'hF8 | 8'($urandom_range(0, 7)));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(2, 4);
            add_sequence(n, $urandom_range(0, n - 2));
        end
        send_string();
    endtask

    // run ends here if traffic stops
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int ph;
        int phase_end;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 72; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 72; end
                default: begin src_idle_pct = 8;  sink_stall_pct = 8;  end
            endcase

            if (ph == 0)
            begin
                // ascii extremes and one character of each length
                str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                              8'hF0, 8'h9F, 8'h98, 8'h80};
                send_string();
                // largest code point the lenient decode can give
                str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
                send_string();
                // junk leads skipped, continuation top bits ignored
                str_bytes = '{8'h80, 8'hF8, 8'hFF, 8'hC3, 8'h41};
                send_string();
                // sequence cut off by the end of the string
                str_bytes = '{8'hE2, 8'h82};
                send_string();
                // string ending on a junk lead
                str_bytes = '{8'hFF};
                send_string();
                // zero payload through a two-byte form
                str_bytes = '{8'hC0, 8'h00};
                send_string();
            end

            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_string();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/utf8_dec_pkg.sv
rtl/core/utf8_byte_decoder.sv
tb/utf8_decode_checker.sv
tb/tb_utf8_byte_decoder.sv
